FILE: hdl/tss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed send scheduler package
// Word types, request and result codes, and default sizes shared by the
// scheduler modules.
// ----------------------------------------------------------------------------
package tss_pkg;

	// Default store sizes.
	localparam int TIMED_SLOTS_DEF     = 8;
	localparam int NOW_QUEUE_DEPTH_DEF = 8;

	// Request modes.
	localparam logic [2:0] MODE_TICK     = 3'd0;
	localparam logic [2:0] MODE_NOW      = 3'd1;
	localparam logic [2:0] MODE_DELAY    = 3'd2;
	localparam logic [2:0] MODE_PERIODIC = 3'd3;
	localparam logic [2:0] MODE_STOP     = 3'd4;

	// Result codes.
	localparam logic       EV_DISPATCH  = 1'b0;
	localparam logic       EV_REJECT    = 1'b1;
	localparam logic [1:0] KIND_NOW      = 2'd0;
	localparam logic [1:0] KIND_ONESHOT  = 2'd1;
	localparam logic [1:0] KIND_PERIODIC = 2'd2;

	// Input word.
	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] dest_ip;
		logic [15:0] dest_port;
		logic [7:0]  message_handle;
		logic [7:0]  wait_seconds;
	} req_t;

	// Result word.
	typedef struct packed {
		logic        event_res;
		logic [1:0]  source_kind;
		logic [31:0] out_ip;
		logic [15:0] out_port;
		logic [7:0]  out_handle;
		logic        last;
	} res_t;

	// Destination of a request as it is stored.
	typedef struct packed {
		logic [31:0] ip;
		logic [15:0] port;
		logic [7:0]  handle;
	} dest_t;

	// One timed slot entry.
	typedef struct packed {
		logic [31:0] deadline;
		logic [7:0]  interval;
		dest_t       dest;
	} slot_ent_t;

	// Write command for the slot memory.
	typedef struct packed {
		logic en;
		logic dl_only;
	} slot_wcmd_t;

	// Destination fields of an input word.
	function automatic dest_t req_dest(input req_t r);
		dest_t d;
		d.ip     = r.dest_ip;
		d.port   = r.dest_port;
		d.handle = r.message_handle;
		return d;
	endfunction

	// Build a result word.
	function automatic res_t make_res(input logic ev, input logic [1:0] kind,
			input dest_t d, input logic lst);
		res_t r;
		r.event_res   = ev;
		r.source_kind = kind;
		r.out_ip      = d.ip;
		r.out_port    = d.port;
		r.out_handle  = d.handle;
		r.last        = lst;
		return r;
	endfunction

endpackage

FILE: hdl/tss_age_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline age compare unit
// Shared subtract and compare used by the slot scan: computes the age of a
// deadline, whether it is due, and whether it beats the best found so far.
// ----------------------------------------------------------------------------
module tss_age_cmp (
	input  logic [31:0] now,
	input  logic [31:0] deadline,
	input  logic        have_best,
	input  logic [31:0] best_age,
	output logic [31:0] age,
	output logic        due,
	output logic        better
);
	// Age modulo 2^32; due when it lies in the lower half of the range.
	assign age    = now - deadline;
	assign due    = ~age[31];
	// Strictly older wins, so ties stay with the lower slot scanned first.
	assign better = ~have_best | (age > best_age);

endmodule

FILE: hdl/tss_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed slot memory
// Deadline, interval and destination of each timed slot, one write port
// and one registered read port.
// ----------------------------------------------------------------------------
module tss_slot_mem #(
	parameter int TIMED_SLOTS = tss_pkg::TIMED_SLOTS_DEF,
	localparam int IDX_W = $clog2(TIMED_SLOTS)
) (
	input  logic                  clk,
	input  tss_pkg::slot_wcmd_t   wr_cmd,
	input  logic [IDX_W-1:0]      wr_idx,
	input  tss_pkg::slot_ent_t    wr_ent,
	input  logic                  rd_en,
	input  logic [IDX_W-1:0]      rd_idx,
	output tss_pkg::slot_ent_t    rd_ent
);
	import tss_pkg::*;

	logic [31:0] deadline_mem [TIMED_SLOTS];
	logic [7:0]  interval_mem [TIMED_SLOTS];
	dest_t       dest_mem     [TIMED_SLOTS];
	slot_ent_t   rd_q;

	// Write port: a rearm updates the deadline only.
	always_ff @(posedge clk) begin
		if (wr_cmd.en) begin
			deadline_mem[wr_idx] <= wr_ent.deadline;
			if (!wr_cmd.dl_only) begin
				interval_mem[wr_idx] <= wr_ent.interval;
				dest_mem[wr_idx]     <= wr_ent.dest;
			end
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q.deadline <= deadline_mem[rd_idx];
			rd_q.interval <= interval_mem[rd_idx];
			rd_q.dest     <= dest_mem[rd_idx];
		end
	end

	assign rd_ent = rd_q;

endmodule

FILE: hdl/tss_now_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Immediate request queue
// Circular queue of destinations waiting for the next tick, with a head
// pointer, a fill count and a registered read of the head entry.
// ----------------------------------------------------------------------------
module tss_now_fifo #(
	parameter int NOW_QUEUE_DEPTH = tss_pkg::NOW_QUEUE_DEPTH_DEF,
	localparam int PTR_W = $clog2(NOW_QUEUE_DEPTH),
	localparam int CNT_W = $clog2(NOW_QUEUE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tss_pkg::dest_t      push_dest,
	input  logic                pop,
	output tss_pkg::dest_t      head_dest,
	output logic [CNT_W-1:0]    count
);
	import tss_pkg::*;

	dest_t              mem [NOW_QUEUE_DEPTH];
	dest_t              rd_q;
	logic [PTR_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W:0]     tail_sum;
	logic [PTR_W-1:0]   tail;

	// Tail is head plus count, wrapped once since the sum stays below twice the depth.
	always_comb begin
		tail_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
		if (tail_sum >= (CNT_W + 1)'(NOW_QUEUE_DEPTH)) begin
			tail_sum = tail_sum - (CNT_W + 1)'(NOW_QUEUE_DEPTH);
		end
		tail = tail_sum[PTR_W-1:0];
	end

	// Storage and registered head read.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail] <= push_dest;
		end
		if (pop) begin
			rd_q <= mem[head_q];
		end
	end

	// Head pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= (head_q == PTR_W'(NOW_QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	assign head_dest = rd_q;
	assign count     = count_q;

endmodule

FILE: hdl/timed_send_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed send scheduler
// Queues send requests for immediate, delayed or periodic dispatch and
// releases them on a once-per-second tick in earliest-deadline order.
// ----------------------------------------------------------------------------
// Usage:
// Request words enter on req_valid/req_ready; result words leave on
// res_valid/res_ready from an output register. A send-now request is
// queued, or rejected with a result word when the queue is full. A
// delayed or periodic request searches the slot valid bits in order for
// the lowest free slot and is rejected when none is free. Stop and
// unused modes yield no word. A tick advances time and, unless halted,
// makes passes of the shared age compare unit over all slots, each
// dispatching the earliest due slot, until a pass finds none due; it
// then dispatches one queued immediate request, if any, and flushes
// the final word. Each result is held in a pending register until the
// next one is known, so that the final word of a tick can carry last.
// req_ready is low while the sequencer is busy with a request; a stalled
// receiver holds the sequencer at its next result.
// Reset clears time, the halt flag, all slot valid bits and the queue
// count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module timed_send_scheduler_top #(
	parameter int TIMED_SLOTS     = tss_pkg::TIMED_SLOTS_DEF,
	parameter int NOW_QUEUE_DEPTH = tss_pkg::NOW_QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  tss_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output tss_pkg::res_t res
);
	import tss_pkg::*;

	localparam int IDX_W = $clog2(TIMED_SLOTS);
	localparam int CNT_W = $clog2(TIMED_SLOTS + 1);
	localparam int QCW   = $clog2(NOW_QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DISP,
		ST_FPOP,
		ST_FDATA,
		ST_FIND,
		ST_FLUSH
	} state_t;

	state_t                 state_q;
	logic [31:0]            now_q;
	logic                   halted_q;
	logic [TIMED_SLOTS-1:0] slot_valid_q;
	logic [CNT_W-1:0]       scan_cnt_q;
	logic                   eval_vld_s1;
	logic [IDX_W-1:0]       eval_idx_s1;
	logic                   have_best_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic [31:0]            best_age_q;
	logic [7:0]             best_int_q;
	dest_t                  best_dest_q;
	req_t                   req_q;
	logic                   pend_vld_q;
	res_t                   pend_q;
	logic                   res_vld_q;
	res_t                   res_q;

	logic                   accept;
	logic                   out_free;
	logic                   scan_issue;
	logic                   pend_move;
	logic                   res_load;
	res_t                   last_word;
	logic [IDX_W-1:0]       scan_idx;
	slot_wcmd_t             slot_wcmd;
	logic [IDX_W-1:0]       slot_widx;
	slot_ent_t              slot_went;
	slot_ent_t              slot_rent;
	logic                   fifo_push;
	logic                   fifo_pop;
	dest_t                  fifo_head;
	logic [QCW-1:0]         fifo_count;
	logic                   fifo_full;
	logic [31:0]            age;
	logic                   due;
	logic                   better;
	logic [7:0]             req_interval;

	// Handshake and shared conditions.
	assign req_ready  = (state_q == ST_IDLE);
	assign accept     = req_valid & req_ready;
	assign out_free   = ~res_vld_q | res_ready;
	assign pend_move  = ~pend_vld_q | out_free;
	assign scan_issue = (state_q == ST_SCAN) && (scan_cnt_q < CNT_W'(TIMED_SLOTS));
	assign scan_idx   = scan_cnt_q[IDX_W-1:0];
	assign fifo_full  = (fifo_count == QCW'(NOW_QUEUE_DEPTH));
	assign req_interval = (req_q.mode == MODE_PERIODIC) ? req_q.wait_seconds : 8'd0;

	// The held result moves to the output register in these states.
	assign res_load = pend_vld_q && out_free &&
		((state_q == ST_DISP) || (state_q == ST_FDATA) || (state_q == ST_FLUSH));

	// The held result marked as the final word of its request.
	always_comb begin
		last_word      = pend_q;
		last_word.last = 1'b1;
	end

	// Slot writes: a new entry from the free-slot search, or a periodic rearm.
	always_comb begin
		slot_wcmd  = '0;
		slot_widx  = scan_idx;
		slot_went.deadline = now_q + 32'(req_q.wait_seconds);
		slot_went.interval = req_interval;
		slot_went.dest     = req_dest(req_q);
		if ((state_q == ST_FIND) && !slot_valid_q[scan_idx]) begin
			slot_wcmd.en = 1'b1;
		end else if ((state_q == ST_DISP) && pend_move && (best_int_q != 8'd0)) begin
			slot_wcmd.en       = 1'b1;
			slot_wcmd.dl_only  = 1'b1;
			slot_widx          = best_idx_q;
			slot_went.deadline = now_q + 32'(best_int_q);
		end
	end

	// Immediate queue control.
	assign fifo_push = accept && (req.mode == MODE_NOW) && !fifo_full;
	assign fifo_pop  = (state_q == ST_FPOP);

	tss_slot_mem #(
		.TIMED_SLOTS(TIMED_SLOTS)
	) u_slot_mem (
		.clk    (clk),
		.wr_cmd (slot_wcmd),
		.wr_idx (slot_widx),
		.wr_ent (slot_went),
		.rd_en  (scan_issue),
		.rd_idx (scan_idx),
		.rd_ent (slot_rent)
	);

	tss_now_fifo #(
		.NOW_QUEUE_DEPTH(NOW_QUEUE_DEPTH)
	) u_now_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_dest (req_dest(req)),
		.pop       (fifo_pop),
		.head_dest (fifo_head),
		.count     (fifo_count)
	);

	tss_age_cmp u_age_cmp (
		.now       (now_q),
		.deadline  (slot_rent.deadline),
		.have_best (have_best_q),
		.best_age  (best_age_q),
		.age       (age),
		.due       (due),
		.better    (better)
	);

	// Sequencer: state, time, slot valid bits, scan registers and result words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			now_q        <= '0;
			halted_q     <= 1'b0;
			slot_valid_q <= '0;
			scan_cnt_q   <= '0;
			eval_vld_s1  <= 1'b0;
			have_best_q  <= 1'b0;
			pend_vld_q   <= 1'b0;
			res_vld_q    <= 1'b0;
		end else begin
			res_vld_q <= res_load | (res_vld_q & ~res_ready);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.mode)
							MODE_TICK: begin
								now_q <= now_q + 32'd1;
								if (!halted_q) begin
									scan_cnt_q  <= '0;
									eval_vld_s1 <= 1'b0;
									have_best_q <= 1'b0;
									state_q     <= ST_SCAN;
								end
							end
							MODE_NOW: begin
								if (fifo_full) begin
									pend_q     <= make_res(EV_REJECT, KIND_NOW, req_dest(req), 1'b0);
									pend_vld_q <= 1'b1;
									state_q    <= ST_FLUSH;
								end
							end
							MODE_DELAY, MODE_PERIODIC: begin
								req_q      <= req;
								scan_cnt_q <= '0;
								state_q    <= ST_FIND;
							end
							MODE_STOP: begin
								halted_q <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					// Issue one slot read and judge the slot read in the cycle before.
					eval_vld_s1 <= scan_issue;
					eval_idx_s1 <= scan_idx;
					if (scan_issue) begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
					if (eval_vld_s1 && slot_valid_q[eval_idx_s1] && due && better) begin
						have_best_q <= 1'b1;
						best_idx_q  <= eval_idx_s1;
						best_age_q  <= age;
						best_int_q  <= slot_rent.interval;
						best_dest_q <= slot_rent.dest;
					end
					if (!scan_issue && !eval_vld_s1) begin
						if (have_best_q) begin
							state_q <= ST_DISP;
						end else if (fifo_count != '0) begin
							state_q <= ST_FPOP;
						end else begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_DISP: begin
					// Release the earlier result, hold this one, then scan again.
					if (pend_move) begin
						if (pend_vld_q) begin
							res_q <= pend_q;
						end
						pend_q <= make_res(EV_DISPATCH,
							(best_int_q != 8'd0) ? KIND_PERIODIC : KIND_ONESHOT,
							best_dest_q, 1'b0);
						pend_vld_q <= 1'b1;
						if (best_int_q == 8'd0) begin
							slot_valid_q[best_idx_q] <= 1'b0;
						end
						scan_cnt_q  <= '0;
						eval_vld_s1 <= 1'b0;
						have_best_q <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_FPOP: begin
					state_q <= ST_FDATA;
				end
				ST_FDATA: begin
					if (pend_move) begin
						if (pend_vld_q) begin
							res_q <= pend_q;
						end
						pend_q     <= make_res(EV_DISPATCH, KIND_NOW, fifo_head, 1'b0);
						pend_vld_q <= 1'b1;
						state_q    <= ST_FLUSH;
					end
				end
				ST_FIND: begin
					// Lowest free slot, one valid bit per cycle.
					if (!slot_valid_q[scan_idx]) begin
						slot_valid_q[scan_idx] <= 1'b1;
						state_q <= ST_IDLE;
					end else if (scan_cnt_q == CNT_W'(TIMED_SLOTS - 1)) begin
						pend_q <= make_res(EV_REJECT,
							(req_interval != 8'd0) ? KIND_PERIODIC : KIND_ONESHOT,
							req_dest(req_q), 1'b0);
						pend_vld_q <= 1'b1;
						state_q    <= ST_FLUSH;
					end else begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					// The held result is the final one of this request.
					if (!pend_vld_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						res_q      <= last_word;
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	// No result may be held back when a new word is taken.
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !pend_vld_q)
		else $error("pending result held while ready");

	// The queue count never passes the depth.
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= QCW'(NOW_QUEUE_DEPTH))
		else $error("immediate queue overfilled");

	// A tick while running starts a slot scan.
	a_tick_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.mode == MODE_TICK) && !halted_q) |=> (state_q == ST_SCAN))
		else $error("tick did not start a scan");

	// A rejection is always the only, hence final, result of its request.
	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.event_res == EV_REJECT)) |-> res.last)
		else $error("rejection without last");
`endif

endmodule
